// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL that carries checks (sbus_frame_parser).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/sbus_pkg.sv
// Shared types and constants of the S.BUS frame parser.
package sbus_pkg;

	// Frame layout.
	localparam int POS_W = 5;
	localparam logic [7:0] SYNC_BYTE = 8'h0F;
	localparam logic [7:0] LOST_FLAG = 8'h0C;
	localparam int FIRST_DATA = 1;
	localparam int LAST_DATA = 22;
	localparam int FLAG_POS = 23;
	localparam logic [POS_W-1:0] FLAG_POS_V = POS_W'(FLAG_POS);
	localparam logic [POS_W-1:0] FIRST_DATA_V = POS_W'(FIRST_DATA);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(24);

	// Channel packing.
	localparam int NUM_CH = 16;
	localparam int CH_W = 4;
	localparam int RAW_W = 11;
	localparam int PACK_W = NUM_CH * RAW_W;
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CH - 1);

	// Scaling: q = floor((32768*|2*raw-1983| + 1639) / 3278), sign from 2*raw-1983.
	localparam int SCALED_W = 16;
	localparam int MAG_W = RAW_W + 1;
	localparam int X_W = MAG_W + 15;
	localparam int Q_W = 15;
	localparam int RECIP_W = 28;
	localparam int RECIP_SH = 39;
	localparam int PROD_W = X_W + RECIP_W;
	localparam logic [MAG_W-1:0] MID2 = MAG_W'(1983);
	localparam logic [X_W-1:0] DIVISOR = X_W'(3278);
	localparam logic [X_W-1:0] HALF_DIV = X_W'(1639);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / 64'd3278);

	// Controller states.
	typedef enum logic [1:0] {
		ST_RECV,
		ST_MUL,
		ST_FIX,
		ST_SEND
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store;
		logic mul_en;
		logic fix_en;
		logic next_ch;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic frame_done;
		logic last_ch;
	} sts_t;

endpackage

// File: hw/rtl/sbus_ctrl.sv
// Controller state machine of the S.BUS frame parser.
module sbus_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  sbus_pkg::sts_t sts,
	output sbus_pkg::cmd_t cmd
);
	import sbus_pkg::*;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RECV;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_RECV: begin
				in_stall  = 1'b0;
				cmd.store = in_valid;
				if (in_valid && sts.frame_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_FIX;
			end
			ST_FIX: begin
				cmd.fix_en = 1'b1;
				state_d    = ST_SEND;
			end
			ST_SEND: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (sts.last_ch) begin
						state_d = ST_RECV;
					end else begin
						cmd.next_ch = 1'b1;
						state_d     = ST_MUL;
					end
				end
			end
			default: begin
				state_d = ST_RECV;
			end
		endcase
	end

endmodule

// File: hw/rtl/sbus_dp.sv
// Datapath of the S.BUS frame parser: frame buffer, unpacking and scaling.
module sbus_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sbus_pkg::cmd_t                    cmd,
	output sbus_pkg::sts_t                    sts,
	input  logic [7:0]                        rx_byte,
	output logic [sbus_pkg::CH_W-1:0]         channel_index,
	output logic [sbus_pkg::RAW_W-1:0]        raw_value,
	output logic signed [sbus_pkg::SCALED_W-1:0] scaled_value,
	output logic                              frame_valid,
	output logic                              last
);
	import sbus_pkg::*;

	logic [7:0]          frame_q [FIRST_DATA:FLAG_POS];
	logic [POS_W-1:0]    pos_q;
	logic [POS_W-1:0]    pos_eff;
	logic                prev_zero_q;
	logic [PACK_W-1:0]   pack;
	logic [PACK_W-1:0]   shreg_q;
	logic [CH_W-1:0]     ch_q;
	logic                flag_ok_q;

	logic [RAW_W-1:0]    raw;
	logic [MAG_W-1:0]    dbl;
	logic                neg;
	logic [MAG_W-1:0]    mag;
	logic [X_W-1:0]      x;
	logic [PROD_W-1:0]   prod;

	logic [RAW_W-1:0]    raw_s1;
	logic                neg_s1;
	logic [X_W-1:0]      x_s1;
	logic [Q_W-1:0]      q0_s1;

	logic [X_W-1:0]      rem;
	logic [Q_W-1:0]      q;
	logic [SCALED_W-1:0] q_ext;

	logic [CH_W-1:0]     channel_index_q;
	logic [RAW_W-1:0]    raw_value_q;
	logic [SCALED_W-1:0] scaled_value_q;
	logic                frame_valid_q;
	logic                last_q;

	// A sync byte right after a zero byte restarts the frame.
	assign pos_eff = (rx_byte == SYNC_BYTE && prev_zero_q) ? '0 : pos_q;
	assign sts.frame_done = (pos_eff == LAST_POS);
	assign sts.last_ch = (ch_q == CH_LAST);

	// Byte position and zero-byte tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			prev_zero_q <= 1'b0;
		end else if (cmd.store) begin
			prev_zero_q <= (rx_byte == 8'h00);
			if (pos_eff == LAST_POS) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_eff + POS_W'(1);
			end
		end
	end

	// Only the data and flag bytes are ever read back.
	always_ff @(posedge clk) begin
		if (cmd.store && pos_eff >= FIRST_DATA_V && pos_eff <= FLAG_POS_V) begin
			frame_q[pos_eff] <= rx_byte;
		end
	end

	// Data bytes laid out as one little-endian bit stream.
	always_comb begin
		for (int b = FIRST_DATA; b <= LAST_DATA; b++) begin
			pack[(b - FIRST_DATA) * 8 +: 8] = frame_q[b];
		end
	end

	// Channel shift register: loaded on frame completion, 11 bits per channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
		end else if (cmd.store && sts.frame_done) begin
			ch_q <= '0;
		end else if (cmd.next_ch) begin
			ch_q <= ch_q + CH_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store && sts.frame_done) begin
			shreg_q   <= pack;
			flag_ok_q <= (frame_q[FLAG_POS] != LOST_FLAG);
		end else if (cmd.next_ch) begin
			shreg_q <= {RAW_W'(0), shreg_q[PACK_W-1:RAW_W]};
		end
	end

	// First scaling stage: magnitude and reciprocal multiply.
	assign raw  = shreg_q[RAW_W-1:0];
	assign dbl  = {raw, 1'b0};
	assign neg  = (dbl < MID2);
	assign mag  = neg ? (MID2 - dbl) : (dbl - MID2);
	assign x    = {mag, 15'b0} + HALF_DIV;
	assign prod = PROD_W'(x) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			raw_s1 <= raw;
			neg_s1 <= neg;
			x_s1   <= x;
			q0_s1  <= prod[RECIP_SH +: Q_W];
		end
	end

	// Second stage: the estimate is low by at most one, fix it and apply the sign.
	assign rem   = x_s1 - (X_W'(q0_s1) * DIVISOR);
	assign q     = q0_s1 + Q_W'(rem >= DIVISOR);
	assign q_ext = {1'b0, q};

	// Result word register.
	always_ff @(posedge clk) begin
		if (cmd.fix_en) begin
			channel_index_q <= ch_q;
			raw_value_q     <= raw_s1;
			scaled_value_q  <= neg_s1 ? (~q_ext + SCALED_W'(1)) : q_ext;
			frame_valid_q   <= flag_ok_q;
			last_q          <= (ch_q == CH_LAST);
		end
	end

	assign channel_index = channel_index_q;
	assign raw_value     = raw_value_q;
	assign scaled_value  = signed'(scaled_value_q);
	assign frame_valid   = frame_valid_q;
	assign last          = last_q;

endmodule

// File: hw/rtl/sbus_frame_parser.sv
// S.BUS frame parser: top level joining the controller and the datapath.
//
// Input channel: one received byte per word on rx_byte (in_valid / in_stall).
// A 0x0F byte right after a 0x00 byte restarts the frame at position 0; after
// the 25th byte the position returns to 0 on its own.
// The 25th byte of a frame starts the unpacking of 16 channels of 11 bits,
// and the block emits 16 result words on the output channel (out_valid /
// out_stall), channel 0 first, last high on channel 15. Each channel passes
// a two-step scaling unit (multiply by the reciprocal of the divisor, then
// one correction step) and is then held in the result register: each
// channel goes through ST_MUL, ST_FIX and ST_SEND and waits in ST_SEND while
// the receiver stalls. in_stall stays high after the last byte of a frame
// until the last result word has been taken.
// A stalled result word holds its value until taken.
// Reset clears the byte position, the resync tracking and the controller; no
// result is pending after reset.
module sbus_frame_parser (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          rx_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sbus_pkg::CH_W-1:0]           channel_index,
	output logic [sbus_pkg::RAW_W-1:0]          raw_value,
	output logic signed [sbus_pkg::SCALED_W-1:0] scaled_value,
	output logic                                frame_valid,
	output logic                                last
);
	import sbus_pkg::*;

	`include "assert_macros.svh"

	cmd_t cmd;
	sts_t sts;

	// Controller.
	sbus_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath.
	sbus_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.rx_byte       (rx_byte),
		.channel_index (channel_index),
		.raw_value     (raw_value),
		.scaled_value  (scaled_value),
		.frame_valid   (frame_valid),
		.last          (last)
	);

	// No byte is taken while result words are pending.
	`ASSERT_SAME(a_no_byte_during_output, out_valid, in_stall, "byte accepted during output")
	// The last mark sits on the final channel only.
	`ASSERT_SAME(a_last_on_final, out_valid, last == (channel_index == CH_LAST), "bad last mark")
	// After the last word is taken the output goes quiet and bytes flow again.
	`ASSERT_NEXT(a_last_ends_frame, out_valid && !out_stall && last, !out_valid && !in_stall, "frame did not end")

endmodule
